// ----- hw/rtl/gshg_pkg.sv -----
// ----------------------------------------------------------------------------
// gshg_pkg
// Shared constants and helpers for the GOOSE sequence header generator.
// ----------------------------------------------------------------------------
`default_nettype none

package gshg_pkg;

  localparam int NAME_LEN_W = 7;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_CB_NAME_LEN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DS_NAME_LEN = 2'd1;

  localparam logic [NAME_LEN_W-1:0] NAME_LEN_MAX = 7'd65;
  localparam logic [7:0]            PDU_FIXED_BYTES = 8'd42;

  // fraction = floor(M / FRAC_DIV), M = ns * 2^15 + FRAC_BIAS
  localparam logic [20:0] FRAC_DIV  = 21'd1953125;
  localparam logic [21:0] FRAC_BIAS = 22'd976562;
  // floor(2^61 / 1e9): reciprocal scaled by 2^37
  localparam logic [31:0] FRAC_RECIP = 32'd2305843009;
  localparam logic [61:0] FRAC_ROUND = 62'h10_0000_0000;
  // first ns value whose fraction rounds to 2^24 or above
  localparam logic [29:0] FRAC_SAT_NS = 30'd999999971;
  localparam logic [23:0] FRAC_MAX    = 24'hFF_FFFF;

  localparam logic [11:0] LIVE_TIME_SHORT_MAX = 12'd128;

  function automatic logic [2:0] byte_len(input logic [31:0] v);
    logic [2:0] len;
    if (v[31:24] != 8'd0) begin
      len = 3'd4;
    end else if (v[23:16] != 8'd0) begin
      len = 3'd3;
    end else if (v[15:8] != 8'd0) begin
      len = 3'd2;
    end else begin
      len = 3'd1;
    end
    return len;
  endfunction

  function automatic logic [11:0] live_time(input logic [31:0] sq);
    logic [11:0] ms;
    if (sq[31:4] != 28'd0) begin
      ms = 12'd4000;
    end else begin
      case (sq[3:0])
        4'd6:    ms = 12'd32;
        4'd7:    ms = 12'd64;
        4'd8:    ms = 12'd128;
        4'd9:    ms = 12'd256;
        4'd10:   ms = 12'd512;
        4'd11:   ms = 12'd1024;
        4'd12:   ms = 12'd2048;
        4'd13,
        4'd14,
        4'd15:   ms = 12'd4000;
        default: ms = 12'd20;
      endcase
    end
    return ms;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/goose_sequence_header_gen_core.sv -----
// ----------------------------------------------------------------------------
// goose_sequence_header_gen_core
// Tracks stNum/sqNum per transmission event and produces the header fields:
// number lengths, timeAllowedToLive, timestamp and PDU length byte.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+---------------------------------
//  in      | sink      | in_valid/in_stall  | breaker, seconds, nanoseconds
//  out     | source    | out_valid/out_stall| stNum, sqNum, lengths, time, pdu
//  cfg     | sink      | cfg_write          | cfg_index, cfg_data
//
//  One word per cycle unless out_stall holds a result; stage 1 feeds output.
//  Stage 1 updates the counters and forms the reciprocal product for the
//  fraction; the output stage corrects the quotient and builds the lengths.
//  Reset clears the counters, name lengths and both valid flags.
//  A word is taken while a result waits, as long as stage 1 is free to move.
// ----------------------------------------------------------------------------
`default_nettype none

module goose_sequence_header_gen_core (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_write,
  input  wire logic [gshg_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [gshg_pkg::NAME_LEN_W-1:0]     cfg_data,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic                                breaker_value,
  input  wire logic [31:0]                         epoch_seconds,
  input  wire logic [29:0]                         subsecond_ns,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic [31:0]                              state_number,
  output logic [2:0]                               state_number_len,
  output logic [31:0]                              sequence_number,
  output logic [2:0]                               sequence_number_len,
  output logic [11:0]                              live_time_ms,
  output logic [1:0]                               live_time_len,
  output logic [31:0]                              time_seconds,
  output logic [23:0]                              time_fraction,
  output logic                                     data_byte,
  output logic                                     state_changed,
  output logic [7:0]                               pdu_length
);

  logic [gshg_pkg::NAME_LEN_W-1:0] cb_len;
  logic [gshg_pkg::NAME_LEN_W-1:0] ds_len;
  logic [gshg_pkg::NAME_LEN_W-1:0] cfg_sat;

  logic [31:0] last_state_number;
  logic [31:0] last_sequence_number;
  logic        last_breaker_value;
  logic        has_sent_before;

  logic        in_accept;
  logic        out_load;
  logic        changed;
  logic [31:0] st_next;
  logic [31:0] sq_next;
  logic [61:0] frac_prod;
  logic [21:0] m_low;

  logic        s1_valid;
  logic [31:0] s1_st;
  logic [31:0] s1_sq;
  logic        s1_changed;
  logic        s1_brk;
  logic [31:0] s1_secs;
  logic [24:0] s1_q0;
  logic [21:0] s1_m_low;
  logic        s1_sat;

  logic [45:0] qd_full;
  logic [21:0] frac_rem;
  logic [24:0] frac_q;
  logic [11:0] tal;
  logic [1:0]  tal_len;
  logic [2:0]  st_len;
  logic [2:0]  sq_len;
  logic [7:0]  pdu;

  // handshake
  assign out_load  = s1_valid && (!out_valid || !out_stall);
  assign in_stall  = s1_valid && !out_load;
  assign in_accept = in_valid && !in_stall;

  // config
  assign cfg_sat = (cfg_data > gshg_pkg::NAME_LEN_MAX) ? gshg_pkg::NAME_LEN_MAX : cfg_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      cb_len <= '0;
      ds_len <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        gshg_pkg::CFG_CB_NAME_LEN: cb_len <= cfg_sat;
        gshg_pkg::CFG_DS_NAME_LEN: ds_len <= cfg_sat;
        default: ;
      endcase
    end
  end

  // counter update
  always_comb begin
    changed = !has_sent_before || (breaker_value != last_breaker_value);
    if (changed) begin
      st_next = last_state_number + 32'd1;
      sq_next = 32'd0;
    end else if (last_sequence_number == 32'hFFFF_FFFF) begin
      st_next = last_state_number;
      sq_next = 32'd1;
    end else begin
      st_next = last_state_number;
      sq_next = last_sequence_number + 32'd1;
    end
  end

  assign frac_prod = 62'(subsecond_ns) * 62'(gshg_pkg::FRAC_RECIP) + gshg_pkg::FRAC_ROUND;
  assign m_low     = {subsecond_ns[6:0], 15'd0} + gshg_pkg::FRAC_BIAS;

  always_ff @(posedge clk) begin
    if (rst) begin
      last_state_number    <= '0;
      last_sequence_number <= '0;
      last_breaker_value   <= 1'b0;
      has_sent_before      <= 1'b0;
    end else if (in_accept) begin
      last_state_number    <= st_next;
      last_sequence_number <= sq_next;
      last_breaker_value   <= breaker_value;
      has_sent_before      <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= 1'b1;
    end else if (out_load) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_st      <= st_next;
      s1_sq      <= sq_next;
      s1_changed <= changed;
      s1_brk     <= breaker_value;
      s1_secs    <= epoch_seconds;
      s1_q0      <= frac_prod[61:37];
      s1_m_low   <= m_low;
      s1_sat     <= (subsecond_ns >= gshg_pkg::FRAC_SAT_NS);
    end
  end

  // output stage: quotient correction, lengths, pdu size
  assign qd_full  = 46'(s1_q0) * 46'(gshg_pkg::FRAC_DIV);
  assign frac_rem = s1_m_low - qd_full[21:0];
  assign frac_q   = s1_q0 + 25'(frac_rem >= 22'(gshg_pkg::FRAC_DIV));

  assign tal     = gshg_pkg::live_time(s1_sq);
  assign tal_len = (tal <= gshg_pkg::LIVE_TIME_SHORT_MAX) ? 2'd1 : 2'd2;
  assign st_len  = gshg_pkg::byte_len(s1_st);
  assign sq_len  = gshg_pkg::byte_len(s1_sq);
  assign pdu     = gshg_pkg::PDU_FIXED_BYTES + {cb_len, 1'b0} + 8'(ds_len)
                   + 8'(tal_len) + 8'(st_len) + 8'(sq_len);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      state_number        <= s1_st;
      state_number_len    <= st_len;
      sequence_number     <= s1_sq;
      sequence_number_len <= sq_len;
      live_time_ms        <= tal;
      live_time_len       <= tal_len;
      time_seconds        <= s1_secs;
      time_fraction       <= s1_sat ? gshg_pkg::FRAC_MAX : frac_q[23:0];
      data_byte           <= s1_brk;
      state_changed       <= s1_changed;
      pdu_length          <= pdu;
    end
  end

endmodule

`default_nettype wire

// ----- tb/tb_goose_sequence_header_gen_core.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_goose_sequence_header_gen_core
// Self-checking bench for the GOOSE sequence header generator. Sends
// transmission events with random input gaps and output stalls, tracks
// stNum/sqNum, and predicts the number lengths, time allowed to live,
// timestamp fraction and PDU length byte. Each result word is compared
// field by field against the oldest expected header.
// ----------------------------------------------------------------------------
module tb_goose_sequence_header_gen_core;

  localparam int CLK_HALF      = 6;
  localparam int CYCLE_LIMIT   = 600000;
  localparam int SETTLE_CYCLES = 8;

  localparam logic [gshg_pkg::CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
  localparam logic [gshg_pkg::CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

  localparam logic [7:0]  PDU_BASE      = 8'd42;
  localparam logic [7:0]  NAME_LEN_CAP  = 8'd65;
  localparam logic [11:0] TTL_SHORT_MAX = 12'd128;
  localparam logic [29:0] NS_LAST_VALID = 30'd999999999;

  typedef struct {
    logic [31:0] st;
    logic [2:0]  st_len;
    logic [31:0] sq;
    logic [2:0]  sq_len;
    logic [11:0] ttl;
    logic [1:0]  ttl_len;
    logic [31:0] secs;
    logic [23:0] frac;
    logic        data;
    logic        changed;
    logic [7:0]  pdu;
  } header_t;

  logic                                clk = 1'b0;
  logic                                rst = 1'b1;
  logic                                cfg_write = 1'b0;
  logic [gshg_pkg::CFG_IDX_W-1:0]      cfg_index = '0;
  logic [gshg_pkg::NAME_LEN_W-1:0]     cfg_data = '0;
  logic                                in_valid = 1'b0;
  logic                                in_stall;
  logic                                breaker_value = 1'b0;
  logic [31:0]                         epoch_seconds = '0;
  logic [29:0]                         subsecond_ns = '0;
  logic                                out_valid;
  logic                                out_stall = 1'b0;
  logic [31:0]                         state_number;
  logic [2:0]                          state_number_len;
  logic [31:0]                         sequence_number;
  logic [2:0]                          sequence_number_len;
  logic [11:0]                         live_time_ms;
  logic [1:0]                          live_time_len;
  logic [31:0]                         time_seconds;
  logic [23:0]                         time_fraction;
  logic                                data_byte;
  logic                                state_changed;
  logic [7:0]                          pdu_length;

  // predictor state
  logic [31:0] st_count = '0;
  logic [31:0] sq_count = '0;
  logic        last_brk = 1'b0;
  logic        sent_any = 1'b0;
  logic [6:0]  cb_len = '0;
  logic [6:0]  ds_len = '0;

  header_t pending_headers[$];
  int      error_count = 0;
  int      cycle_count = 0;
  int      stall_left = 0;
  bit      gaps_on = 1'b1;
  bit      stalls_on = 1'b1;
  logic    cur_brk = 1'b0;

  goose_sequence_header_gen_core dut (
    .clk                 (clk),
    .rst                 (rst),
    .cfg_write           (cfg_write),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .breaker_value       (breaker_value),
    .epoch_seconds       (epoch_seconds),
    .subsecond_ns        (subsecond_ns),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .state_number        (state_number),
    .state_number_len    (state_number_len),
    .sequence_number     (sequence_number),
    .sequence_number_len (sequence_number_len),
    .live_time_ms        (live_time_ms),
    .live_time_len       (live_time_len),
    .time_seconds        (time_seconds),
    .time_fraction       (time_fraction),
    .data_byte           (data_byte),
    .state_changed       (state_changed),
    .pdu_length          (pdu_length)
  );

  initial begin
    forever #(CLK_HALF) clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic int pick_span();
    int r;
    r = $urandom_range(0, 99);
    if (r < 85) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [2:0] min_bytes(input logic [31:0] v);
    if (v > 32'h00FF_FFFF) return 3'd4;
    if (v > 32'h0000_FFFF) return 3'd3;
    if (v > 32'h0000_00FF) return 3'd2;
    return 3'd1;
  endfunction

  function automatic logic [11:0] ttl_for_seq(input logic [31:0] sq);
    if (sq <= 32'd5) return 12'd20;
    if (sq >= 32'd13) return 12'd4000;
    return 12'd32 << (sq - 32'd6);
  endfunction

  function automatic logic [7:0] capped_len(input logic [6:0] n);
    return ({1'b0, n} > NAME_LEN_CAP) ? NAME_LEN_CAP : {1'b0, n};
  endfunction

  // advances the stNum/sqNum state and returns the header for one event
  function automatic header_t predict_header(input logic brk, input logic [31:0] secs,
                                             input logic [29:0] ns);
    header_t     h;
    logic [63:0] scaled;
    h.changed = !sent_any || (brk != last_brk);
    if (h.changed) begin
      st_count = st_count + 32'd1;
      sq_count = '0;
    end else if (sq_count == 32'hFFFF_FFFF) begin
      sq_count = 32'd1;
    end else begin
      sq_count = sq_count + 32'd1;
    end
    last_brk = brk;
    sent_any = 1'b1;
    h.st      = st_count;
    h.st_len  = min_bytes(st_count);
    h.sq      = sq_count;
    h.sq_len  = min_bytes(sq_count);
    h.ttl     = ttl_for_seq(sq_count);
    h.ttl_len = (h.ttl <= TTL_SHORT_MAX) ? 2'd1 : 2'd2;
    h.secs    = secs;
    scaled    = ({10'd0, ns, 24'd0} + 64'd500000000) / 64'd1000000000;
    h.frac    = (scaled > 64'hFF_FFFF) ? 24'hFF_FFFF : scaled[23:0];
    h.data    = brk;
    h.pdu     = PDU_BASE + (capped_len(cb_len) << 1) + capped_len(ds_len)
                + {6'd0, h.ttl_len} + {5'd0, h.st_len} + {5'd0, h.sq_len};
    return h;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      error_count++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : check_results
    header_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_headers.size() == 0) begin
        error_count++;
        $display("%0t: unexpected result word, expected none, actual stNum %0d sqNum %0d",
                 $time, state_number, sequence_number);
      end else begin
        want = pending_headers.pop_front();
        check_field("state_number", want.st, state_number);
        check_field("state_number_len", 32'(want.st_len), 32'(state_number_len));
        check_field("sequence_number", want.sq, sequence_number);
        check_field("sequence_number_len", 32'(want.sq_len), 32'(sequence_number_len));
        check_field("live_time_ms", 32'(want.ttl), 32'(live_time_ms));
        check_field("live_time_len", 32'(want.ttl_len), 32'(live_time_len));
        check_field("time_seconds", want.secs, time_seconds);
        check_field("time_fraction", 32'(want.frac), 32'(time_fraction));
        check_field("data_byte", 32'(want.data), 32'(data_byte));
        check_field("state_changed", 32'(want.changed), 32'(state_changed));
        check_field("pdu_length", 32'(want.pdu), 32'(pdu_length));
      end
    end
  end

  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= 1'b1;
    end else if (stalls_on && $urandom_range(0, 99) < 25) begin
      stall_left <= pick_span() - 1;
      out_stall  <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic send_event(input logic brk, input logic [31:0] secs, input logic [29:0] ns);
    int      gap;
    header_t h;
    in_valid      <= 1'b1;
    breaker_value <= brk;
    epoch_seconds <= secs;
    subsecond_ns  <= ns;
    do @(posedge clk); while (in_stall);
    h = predict_header(brk, secs, ns);
    pending_headers = {pending_headers, h};
    cur_brk = brk;
    gap = (gaps_on && $urandom_range(0, 99) < 30) ? pick_span() : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_headers.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // caller lowers cfg_write after the last write of a burst
  task automatic cfg_put(input logic [gshg_pkg::CFG_IDX_W-1:0] idx,
                         input logic [gshg_pkg::NAME_LEN_W-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    if (idx == gshg_pkg::CFG_CB_NAME_LEN) cb_len = val;
    else if (idx == gshg_pkg::CFG_DS_NAME_LEN) ds_len = val;
  endtask

  task automatic set_name_lengths(input logic [6:0] cb, input logic [6:0] ds);
    wait_drained();
    cfg_put(gshg_pkg::CFG_CB_NAME_LEN, cb);
    cfg_put(gshg_pkg::CFG_DS_NAME_LEN, ds);
    cfg_write <= 1'b0;
  endtask

  function automatic logic [29:0] corner_ns(input int i);
    case (i)
      0:       return 30'd0;
      1:       return 30'd1;
      2:       return 30'd29;
      3:       return 30'd30;
      4:       return 30'd500000000;
      5:       return 30'd999999970;
      6:       return 30'd999999971;
      7:       return NS_LAST_VALID;
      8:       return 30'd1000000000;
      9:       return 30'h3FFF_FFFF;
      default: return 30'($urandom_range(0, 999999999));
    endcase
  endfunction

  function automatic logic [29:0] random_ns();
    int r;
    r = $urandom_range(0, 9);
    if (r < 7) return 30'($urandom_range(0, 999999999));
    if (r == 7) return 30'($urandom_range(999999900, 999999999));
    if (r == 8) return 30'($urandom_range(0, 99));
    return 30'($urandom_range(0, 32'h3FFF_FFFF));
  endfunction

  // first event counts as a change even with breaker open; then walk sqNum
  // through the whole time-allowed-to-live table
  task automatic test_first_event_and_ttl_table();
    set_name_lengths(7'd0, 7'd0);
    for (int i = 0; i < 14; i++) begin
      send_event(1'b0, (i == 1) ? 32'hFFFF_FFFF : ((i == 0) ? 32'd0 : $urandom()),
                 corner_ns(i));
    end
    send_event(1'b1, $urandom(), corner_ns(8));
    send_event(1'b0, $urandom(), corner_ns(9));
  endtask

  task automatic test_name_length_saturation();
    set_name_lengths(7'd65, 7'd65);
    send_event(cur_brk, $urandom(), random_ns());
    set_name_lengths(7'd127, 7'd66);
    send_event(~cur_brk, $urandom(), random_ns());
    set_name_lengths(7'd0, 7'd127);
    send_event(cur_brk, $urandom(), random_ns());
    set_name_lengths(7'd127, 7'd0);
    send_event(cur_brk, $urandom(), random_ns());
  endtask

  // writes to indexes past the last register must not change anything
  task automatic test_spare_indexes();
    wait_drained();
    cfg_put(CFG_SPARE_2, 7'h7F);
    cfg_put(CFG_SPARE_3, 7'h00);
    cfg_write <= 1'b0;
    send_event(~cur_brk, $urandom(), random_ns());
  endtask

  task automatic test_random_traffic();
    int          words;
    int          toggle_pm;
    logic [6:0]  cb;
    logic [6:0]  ds;
    for (int p = 0; p < 6; p++) begin
      case (p)
        0:       begin words = 300; toggle_pm = 700; cb = 7'd0;   ds = 7'd0;   end
        1:       begin words = 400; toggle_pm = 0;   cb = 7'd65;  ds = 7'd1;   end
        2:       begin words = 200; toggle_pm = 200; cb = 7'($urandom_range(0, 127));
                                                     ds = 7'($urandom_range(0, 127)); end
        3:       begin words = 200; toggle_pm = 2;   cb = 7'($urandom_range(0, 127));
                                                     ds = 7'($urandom_range(0, 127)); end
        4:       begin words = 200; toggle_pm = 700; cb = 7'd127; ds = 7'd127; end
        default: begin words = 200; toggle_pm = 50;  cb = 7'($urandom_range(0, 127));
                                                     ds = 7'd65; end
      endcase
      set_name_lengths(cb, ds);
      if (p == 2) begin
        @(posedge clk);
        cfg_put(CFG_SPARE_3, 7'($urandom_range(0, 127)));
        cfg_write <= 1'b0;
      end
      gaps_on   = (p % 3 != 1);
      stalls_on = (p % 3 != 1);
      for (int i = 0; i < words; i++) begin
        send_event(($urandom_range(0, 999) < toggle_pm) ? ~cur_brk : cur_brk,
                   $urandom(), random_ns());
      end
    end
    gaps_on   = 1'b1;
    stalls_on = 1'b1;
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_first_event_and_ttl_table();
    test_name_length_saturation();
    test_spare_indexes();
    test_random_traffic();
    wait_drained();
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
